### rtl/core/owb_pkg.sv
// Shared types and constants for the one-wire bus master core.
package owb_pkg;

   // Bits sent or received per byte command (1 to 8).
   localparam int unsigned BITS_PER_BYTE = 8;

   // Widths of the configuration port.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 10;

   // Command codes carried by the mode field.
   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_RESET = 2'd1,
      MODE_WRITE = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RESET_LOW     = 3'd0,
      CSR_PRESENCE_WAIT = 3'd1,
      CSR_SLOT_START    = 3'd2,
      CSR_WRITE_HOLD    = 3'd3,
      CSR_READ_SAMPLE   = 3'd4,
      CSR_RECOVERY      = 3'd5
   } csr_index_type;

   // Register reset values.
   localparam logic [9:0] RESET_LOW_DEF     = 10'd500;
   localparam logic [9:0] PRESENCE_WAIT_DEF = 10'd70;
   localparam logic [5:0] SLOT_START_DEF    = 6'd2;
   localparam logic [6:0] WRITE_HOLD_DEF    = 7'd58;
   localparam logic [5:0] READ_SAMPLE_DEF   = 6'd10;
   localparam logic [5:0] RECOVERY_DEF      = 6'd2;

   // Sequencer phases.
   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_RST_LOW    = 3'd1,
      PH_RST_WAIT   = 3'd2,
      PH_SLOT_START = 3'd3,
      PH_WRITE_HOLD = 3'd4,
      PH_READ_WAIT  = 3'd5,
      PH_RECOVER    = 3'd6
   } phase_type;

   // Slot timing registers.
   typedef struct packed {
      logic [9:0] reset_low_time;
      logic [9:0] presence_wait_time;
      logic [5:0] slot_start_time;
      logic [6:0] write_hold_time;
      logic [5:0] read_sample_delay;
      logic [5:0] recovery_time;
   } cfg_type;

   // One tick of input.
   typedef struct packed {
      mode_type   mode;
      logic [7:0] write_data;
      logic       line_level;
   } item_type;

   // One tick of output.
   typedef struct packed {
      logic       drive_enable;
      logic       drive_level;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] read_data;
   } result_type;

   // Sequencer state carried from tick to tick.
   typedef struct packed {
      phase_type  phase;
      logic [9:0] tick_count;
      logic [2:0] bit_index;
      logic [7:0] shift_byte;
      logic       presence_flag;
      mode_type   op_kind;
      logic [7:0] last_read;
   } state_type;

endpackage

### rtl/core/owb_step.sv
// Combinational one-tick step of the bus sequencer: next state and result.
module owb_step (
   input  owb_pkg::state_type  state_cur,
   input  owb_pkg::cfg_type    cfg,
   input  owb_pkg::item_type   item,
   output owb_pkg::state_type  state_nxt,
   output owb_pkg::result_type result
);
   import owb_pkg::*;

   localparam logic [3:0] LAST_BIT = 4'(BITS_PER_BYTE);

   // A zero timing register counts as one tick.
   function automatic logic [9:0] at_least_one(input logic [9:0] v);
      return (v == 10'd0) ? 10'd1 : v;
   endfunction

   state_type  eff;
   logic       start;
   logic [9:0] len;
   logic [9:0] tick_inc;
   logic       expire;
   logic       last_bit;

   // A command is taken only while idle; it opens its first phase this tick.
   always_comb begin
      start = (state_cur.phase == PH_IDLE) && (item.mode != MODE_NONE);
      eff   = state_cur;
      if (start) begin
         eff.op_kind    = item.mode;
         eff.tick_count = 10'd0;
         eff.bit_index  = 3'd0;
         if (item.mode == MODE_RESET) begin
            eff.phase = PH_RST_LOW;
         end else begin
            eff.phase      = PH_SLOT_START;
            eff.shift_byte = (item.mode == MODE_WRITE) ? item.write_data : 8'd0;
         end
      end
   end

   // Length of the current phase from the timing registers.
   always_comb begin
      unique case (eff.phase)
         PH_RST_LOW:    len = at_least_one(cfg.reset_low_time);
         PH_RST_WAIT:   len = at_least_one(cfg.presence_wait_time);
         PH_SLOT_START: len = at_least_one({4'd0, cfg.slot_start_time});
         PH_WRITE_HOLD: len = at_least_one({3'd0, cfg.write_hold_time});
         PH_READ_WAIT:  len = at_least_one({4'd0, cfg.read_sample_delay});
         default:       len = at_least_one({4'd0, cfg.recovery_time});
      endcase
      tick_inc = eff.tick_count + 10'd1;
      expire   = tick_inc >= len;
      last_bit = ({1'b0, eff.bit_index} + 4'd1) >= LAST_BIT;
   end

   // Next state.
   always_comb begin
      state_nxt = eff;
      if (eff.phase != PH_IDLE) begin
         state_nxt.tick_count = expire ? 10'd0 : tick_inc;
         if (expire) begin
            unique case (eff.phase)
               PH_RST_LOW: begin
                  state_nxt.phase = PH_RST_WAIT;
               end
               PH_RST_WAIT: begin
                  state_nxt.presence_flag = ~item.line_level;
                  state_nxt.phase         = PH_IDLE;
               end
               PH_SLOT_START: begin
                  state_nxt.phase = (eff.op_kind == MODE_WRITE) ? PH_WRITE_HOLD
                                                               : PH_READ_WAIT;
               end
               PH_WRITE_HOLD: begin
                  state_nxt.phase = PH_RECOVER;
               end
               PH_READ_WAIT: begin
                  if (item.line_level) begin
                     state_nxt.shift_byte[eff.bit_index] = 1'b1;
                  end
                  state_nxt.phase = PH_RECOVER;
               end
               PH_RECOVER: begin
                  if (last_bit) begin
                     if (eff.op_kind == MODE_READ) begin
                        state_nxt.last_read = eff.shift_byte;
                     end
                     state_nxt.phase = PH_IDLE;
                  end else begin
                     state_nxt.bit_index = eff.bit_index + 3'd1;
                     state_nxt.phase     = PH_SLOT_START;
                  end
               end
               default: begin
                  state_nxt.phase = PH_IDLE;
               end
            endcase
         end
      end
   end

   // Line drive and status for this tick.
   always_comb begin
      result.drive_enable = 1'b0;
      result.drive_level  = 1'b0;
      result.busy_res     = (eff.phase != PH_IDLE);
      result.done_res     = 1'b0;
      unique case (eff.phase)
         PH_RST_LOW, PH_SLOT_START: begin
            result.drive_enable = 1'b1;
         end
         PH_WRITE_HOLD: begin
            result.drive_enable = 1'b1;
            result.drive_level  = eff.shift_byte[eff.bit_index];
         end
         PH_RST_WAIT: begin
            result.done_res = expire;
         end
         PH_RECOVER: begin
            result.done_res = expire && last_bit;
         end
         default: begin
            result.done_res = 1'b0;
         end
      endcase
      result.presence  = state_nxt.presence_flag;
      result.read_data = state_nxt.last_read;
   end

endmodule

### rtl/core/onewire_bus_master_core.sv
// Top level of the one-wire bus master: handshake, timing registers and state.
// A taken tick waits in the input register until the result register can load it.
// Throughput: one tick per cycle unless rsp_stall holds; the single step sets it.
// An input register and a result register let a new tick enter while a result waits.
// Reset: synchronous, active high; phase idle, counters and bytes zero, timing
// registers at their default values.
module onewire_bus_master_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_mode,
   input  logic [7:0]                         req_write_data,
   input  logic                               req_line_level,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_drive_enable,
   output logic                               rsp_drive_level,
   output logic                               rsp_busy_res,
   output logic                               rsp_done_res,
   output logic                               rsp_presence,
   output logic [7:0]                         rsp_read_data,
   input  logic                               csr_wen,
   input  logic [owb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [owb_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import owb_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   item_type   item_ff, item_in;
   result_type result_ff, result_in, step_result;
   logic       in_valid_ff, in_valid_in;
   logic       out_valid_ff, out_valid_in;
   logic       req_take;
   logic       advance;

   // Handshake: the input register empties when the result register can load.
   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
      req_stall    = in_valid_ff && !advance;
      req_take     = req_valid && !req_stall;
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
      item_in      = req_take ? item_type'{mode: mode_type'(req_mode),
                                           write_data: req_write_data,
                                           line_level: req_line_level}
                              : item_ff;
      result_in    = advance ? step_result : result_ff;
   end

   // Timing register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_RESET_LOW:     cfg_in.reset_low_time     = csr_wdata;
            CSR_PRESENCE_WAIT: cfg_in.presence_wait_time = csr_wdata;
            CSR_SLOT_START:    cfg_in.slot_start_time    = csr_wdata[5:0];
            CSR_WRITE_HOLD:    cfg_in.write_hold_time    = csr_wdata[6:0];
            CSR_READ_SAMPLE:   cfg_in.read_sample_delay  = csr_wdata[5:0];
            CSR_RECOVERY:      cfg_in.recovery_time      = csr_wdata[5:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   owb_step u_step (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .item      (item_ff),
      .state_nxt (state_in),
      .result    (step_result)
   );

   // Control, state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff       <= '{reset_low_time:     RESET_LOW_DEF,
                           presence_wait_time: PRESENCE_WAIT_DEF,
                           slot_start_time:    SLOT_START_DEF,
                           write_hold_time:    WRITE_HOLD_DEF,
                           read_sample_delay:  READ_SAMPLE_DEF,
                           recovery_time:      RECOVERY_DEF};
         state_ff     <= '{phase: PH_IDLE, op_kind: MODE_NONE, default: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_drive_enable = result_ff.drive_enable;
   assign rsp_drive_level  = result_ff.drive_level;
   assign rsp_busy_res     = result_ff.busy_res;
   assign rsp_done_res     = result_ff.done_res;
   assign rsp_presence     = result_ff.presence;
   assign rsp_read_data    = result_ff.read_data;

endmodule
